// ----- hdl/stvk_pkg.sv -----
// stvk_pkg: shared types, constants and saturating Q32.32 helpers for the
// StVK membrane force/Hessian block. No dependencies.
package stvk_pkg;

   typedef logic signed [63:0] q64_type;

   localparam q64_type Q_ONE = 64'sh0000_0001_0000_0000;
   localparam q64_type Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam q64_type Q_MIN = 64'sh8000_0000_0000_0000;
   localparam q64_type Q_ZERO = 64'sh0;

   // configuration port
   localparam int CSR_AW = 4;
   typedef enum logic [1:0] {
      CSR_SHEAR = 2'd0,
      CSR_LAME  = 2'd1,
      CSR_FLOOR = 2'd2
   } csr_index_type;

   // corner codes
   typedef enum logic [1:0] {
      CORNER_0   = 2'd0,
      CORNER_1   = 2'd1,
      CORNER_2   = 2'd2,
      CORNER_BAD = 2'd3
   } corner_type;

   // upper-triangle index pairs of the 3x3 Hessian
   localparam int NPAIR = 6;
   localparam int PAIR_I [NPAIR] = '{0, 0, 0, 1, 1, 2};
   localparam int PAIR_J [NPAIR] = '{0, 1, 2, 1, 2, 2};

   function automatic q64_type sat_add(q64_type a, q64_type b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic q64_type sat_sub(q64_type a, q64_type b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
      return s[63:0];
   endfunction

   function automatic q64_type sat_neg(q64_type a);
      return (a == Q_MIN) ? Q_MAX : -a;
   endfunction

   // product with one half, rounded half away from zero
   function automatic q64_type q_half(q64_type a);
      logic signed [64:0] s;
      logic signed [64:0] m;
      logic signed [64:0] h;
      s = {a[63], a};
      m = a[63] ? -s : s;
      h = (m + 65'sd1) >>> 1;
      return a[63] ? -h[63:0] : h[63:0];
   endfunction

   // product with two, saturating
   function automatic q64_type q_two(q64_type a);
      return sat_add(a, a);
   endfunction

   // signed Q16.16 to Q32.32
   function automatic q64_type widen_s(logic [31:0] v);
      return {{16{v[31]}}, v, 16'h0000};
   endfunction

   // unsigned Q16.16 to Q32.32
   function automatic q64_type widen_u(logic [31:0] v);
      return {16'h0000, v, 16'h0000};
   endfunction

endpackage

// ----- hdl/stvk_chan_if.sv -----
// stvk channel interfaces: request word (triangle, rest inverse, corner)
// and response word (force, Hessian, error). Uses no package.
interface stvk_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] edge_a_x;
   logic signed [31:0] edge_a_y;
   logic signed [31:0] edge_a_z;
   logic signed [31:0] edge_b_x;
   logic signed [31:0] edge_b_y;
   logic signed [31:0] edge_b_z;
   logic signed [31:0] rest_inv_00;
   logic signed [31:0] rest_inv_01;
   logic signed [31:0] rest_inv_10;
   logic signed [31:0] rest_inv_11;
   logic        [1:0]  corner_index;

   modport source (output valid, edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y,
                   edge_b_z, rest_inv_00, rest_inv_01, rest_inv_10, rest_inv_11,
                   corner_index, input ready);
   modport sink (input valid, edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y,
                 edge_b_z, rest_inv_00, rest_inv_01, rest_inv_10, rest_inv_11,
                 corner_index, output ready);
endinterface

interface stvk_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] force_x;
   logic signed [63:0] force_y;
   logic signed [63:0] force_z;
   logic signed [63:0] hess_xx;
   logic signed [63:0] hess_xy;
   logic signed [63:0] hess_xz;
   logic signed [63:0] hess_yy;
   logic signed [63:0] hess_yz;
   logic signed [63:0] hess_zz;
   logic               order_error;

   modport source (output valid, force_x, force_y, force_z, hess_xx, hess_xy, hess_xz,
                   hess_yy, hess_yz, hess_zz, order_error, input ready);
   modport sink (input valid, force_x, force_y, force_z, hess_xx, hess_xy, hess_xz,
                 hess_yy, hess_yz, hess_zz, order_error, output ready);
endinterface

// ----- hdl/stvk_qmul.sv -----
// stvk_qmul: two-stage Q32.32 multiplier, round half away from zero,
// saturating. Four 32x32 partial products. Depends on stvk_pkg.
module stvk_qmul (
   input  logic             clock,
   input  logic             en,
   input  stvk_pkg::q64_type a,
   input  stvk_pkg::q64_type b,
   output stvk_pkg::q64_type p
);

   logic [63:0] ma, mb;
   logic        neg_ff;
   logic [63:0] p00_ff, p01_ff, p10_ff, p11_ff;
   logic [127:0] full;
   logic [63:0]  q;
   stvk_pkg::q64_type p_ff, p_in;

   // stage A: magnitudes and partial products
   always_comb begin
      ma = a[63] ? 64'(-a) : 64'(a);
      mb = b[63] ? 64'(-b) : 64'(b);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff <= a[63] ^ b[63];
         p00_ff <= 64'(ma[31:0])  * 64'(mb[31:0]);
         p01_ff <= 64'(ma[31:0])  * 64'(mb[63:32]);
         p10_ff <= 64'(ma[63:32]) * 64'(mb[31:0]);
         p11_ff <= 64'(ma[63:32]) * 64'(mb[63:32]);
      end
   end

   // stage B: sum, round, saturate, sign
   always_comb begin
      full = {p11_ff, 64'h0} + {32'h0, p01_ff, 32'h0} + {32'h0, p10_ff, 32'h0}
             + {64'h0, p00_ff} + 128'h8000_0000;
      q = full[95:32];
      if (|full[127:96]) p_in = neg_ff ? stvk_pkg::Q_MIN : stvk_pkg::Q_MAX;
      else if (!neg_ff)  p_in = q[63] ? stvk_pkg::Q_MAX : $signed(q);
      else               p_in = q[63] ? stvk_pkg::Q_MIN : -$signed(q);
   end

   always_ff @(posedge clock) begin
      if (en) p_ff <= p_in;
   end

   assign p = p_ff;

endmodule

// ----- hdl/stvk_dly.sv -----
// stvk_dly: stallable delay line that keeps side values level with the
// multiplier stages. No dependencies.
module stvk_dly #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

// ----- hdl/stvk_triangle_force_hessian.sv -----
// stvk_triangle_force_hessian: StVK membrane force and 3x3 Hessian for one
// triangle corner. Depends on stvk_pkg, stvk_chan_if, stvk_qmul, stvk_dly.
//
// Usage
//   req_word carries one triangle/vertex pair per word (edges, rest inverse,
//   corner index); rsp_word returns force, the six upper Hessian entries and
//   order_error. Both are valid/ready channels.
//   csr_* is an APB-style port: shear_modulus at 0x0, lame_first at 0x4,
//   strain_floor at 0x8. Write only while the pipeline is empty.
// Timing
//   A word passes through five chained levels of two-stage multipliers, the
//   first stage loading at the accepting edge, and then the output register.
//   One word is accepted per cycle while the pipeline is not stalled.
// Reset
//   reset (synchronous) empties the pipeline and loads mu=0, lambda=0,
//   floor=1.
// Stall
//   The whole pipeline holds while the output word waits and rsp_word.ready
//   is low; req_word.ready is high whenever the output register is free or
//   being emptied. Nothing is dropped or repeated.
module stvk_triangle_force_hessian (
   input  logic                          clock,
   input  logic                          reset,
   stvk_req_if.sink                      req_word,
   stvk_rsp_if.source                    rsp_word,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [stvk_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   localparam int N1 = 15;
   localparam int N2 = 21;
   localparam int N3 = 56;
   localparam int N4 = 30;
   localparam int N5 = 6;
   localparam int NV = 10;

   // ---------------- configuration registers ----------------
   logic [31:0] mu_ff, lam_ff, floor_ff;
   logic        csr_wr;
   stvk_pkg::csr_index_type csr_idx;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = stvk_pkg::csr_index_type'(csr_paddr[3:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff    <= 32'd0;
         lam_ff   <= 32'd0;
         floor_ff <= 32'd1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            stvk_pkg::CSR_SHEAR: mu_ff    <= csr_pwdata;
            stvk_pkg::CSR_LAME:  lam_ff   <= csr_pwdata;
            stvk_pkg::CSR_FLOOR: floor_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         stvk_pkg::CSR_SHEAR: csr_prdata = mu_ff;
         stvk_pkg::CSR_LAME:  csr_prdata = lam_ff;
         stvk_pkg::CSR_FLOOR: csr_prdata = floor_ff;
         default:             csr_prdata = 32'd0;
      endcase
   end

   stvk_pkg::q64_type mu, lam, tmu;
   assign mu  = stvk_pkg::widen_u(mu_ff);
   assign lam = stvk_pkg::widen_u(lam_ff);
   assign tmu = stvk_pkg::q_two(mu);

   // ---------------- pipeline control ----------------
   logic          en, acc;
   logic [NV-1:0] vld_ff;
   logic          rsp_vld_ff;

   assign en             = !rsp_vld_ff || rsp_word.ready;
   assign req_word.ready = en;
   assign acc            = req_word.valid && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[NV-2:0], acc};
         rsp_vld_ff <= vld_ff[NV-1];
      end
   end

   // ---------------- level 1: F products and corner weights ----------------
   stvk_pkg::q64_type ea [3], eb [3];
   stvk_pkg::q64_type d00, d01, d10, d11, k0, k1;
   stvk_pkg::q64_type l1_a [N1], l1_b [N1], l1_p [N1];

   always_comb begin
      ea[0] = stvk_pkg::widen_s(req_word.edge_a_x);
      ea[1] = stvk_pkg::widen_s(req_word.edge_a_y);
      ea[2] = stvk_pkg::widen_s(req_word.edge_a_z);
      eb[0] = stvk_pkg::widen_s(req_word.edge_b_x);
      eb[1] = stvk_pkg::widen_s(req_word.edge_b_y);
      eb[2] = stvk_pkg::widen_s(req_word.edge_b_z);
      d00 = stvk_pkg::widen_s(req_word.rest_inv_00);
      d01 = stvk_pkg::widen_s(req_word.rest_inv_01);
      d10 = stvk_pkg::widen_s(req_word.rest_inv_10);
      d11 = stvk_pkg::widen_s(req_word.rest_inv_11);
      unique case (stvk_pkg::corner_type'(req_word.corner_index))
         stvk_pkg::CORNER_0: begin
            k0 = stvk_pkg::sat_neg(stvk_pkg::sat_add(d00, d10));
            k1 = stvk_pkg::sat_neg(stvk_pkg::sat_add(d01, d11));
         end
         stvk_pkg::CORNER_1: begin
            k0 = d00;
            k1 = d01;
         end
         default: begin
            k0 = d10;
            k1 = d11;
         end
      endcase
      for (int i = 0; i < 3; i++) begin
         l1_a[i]   = ea[i]; l1_b[i]   = d00;
         l1_a[3+i] = eb[i]; l1_b[3+i] = d01;
         l1_a[6+i] = ea[i]; l1_b[6+i] = d10;
         l1_a[9+i] = eb[i]; l1_b[9+i] = d11;
      end
      l1_a[12] = k0; l1_b[12] = k0;
      l1_a[13] = k1; l1_b[13] = k1;
      l1_a[14] = k0; l1_b[14] = k1;
   end

   for (genvar g = 0; g < N1; g++) begin : g_l1
      stvk_qmul u_mul (.clock(clock), .en(en), .a(l1_a[g]), .b(l1_b[g]), .p(l1_p[g]));
   end

   // ---------------- level 2: Gram products ----------------
   stvk_pkg::q64_type f0 [3], f1 [3];
   stvk_pkg::q64_type l2_a [N2], l2_b [N2], l2_p [N2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f0[i] = stvk_pkg::sat_add(l1_p[i], l1_p[3+i]);
         f1[i] = stvk_pkg::sat_add(l1_p[6+i], l1_p[9+i]);
      end
      for (int q = 0; q < stvk_pkg::NPAIR; q++) begin
         l2_a[q]   = f0[stvk_pkg::PAIR_I[q]]; l2_b[q]   = f0[stvk_pkg::PAIR_J[q]];
         l2_a[6+q] = f1[stvk_pkg::PAIR_I[q]]; l2_b[6+q] = f1[stvk_pkg::PAIR_J[q]];
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            l2_a[12+3*i+j] = f0[i];
            l2_b[12+3*i+j] = f1[j];
         end
      end
   end

   for (genvar g = 0; g < N2; g++) begin : g_l2
      stvk_qmul u_mul (.clock(clock), .en(en), .a(l2_a[g]), .b(l2_b[g]), .p(l2_p[g]));
   end

   // F columns and corner squares follow the multipliers to level 4
   logic [6*64-1:0] f_bus, fd_bus;
   logic [3*64-1:0] s_bus, sd_bus;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         f_bus[64*i +: 64]     = f0[i];
         f_bus[64*(3+i) +: 64] = f1[i];
         s_bus[64*i +: 64]     = l1_p[12+i];
      end
   end
   stvk_dly #(.WIDTH(6*64), .DEPTH(4)) u_f_dly (.clock(clock), .en(en), .d(f_bus), .q(fd_bus));
   stvk_dly #(.WIDTH(3*64), .DEPTH(4)) u_s_dly (.clock(clock), .en(en), .d(s_bus), .q(sd_bus));

   // ---------------- level 3: strain and material terms ----------------
   stvk_pkg::q64_type f00, f11, f01, g00, g11, g01, hic, trg;
   stvk_pkg::q64_type pa, pb, pc, pd, in00, in11, dgf0, dgf1, dgf01;
   stvk_pkg::q64_type l3_a [N3], l3_b [N3], l3_p [N3];

   always_comb begin
      f00 = stvk_pkg::sat_add(stvk_pkg::sat_add(l2_p[0], l2_p[3]), l2_p[5]);
      f11 = stvk_pkg::sat_add(stvk_pkg::sat_add(l2_p[6], l2_p[9]), l2_p[11]);
      f01 = stvk_pkg::sat_add(stvk_pkg::sat_add(l2_p[12], l2_p[16]), l2_p[20]);
      g00 = stvk_pkg::q_half(stvk_pkg::sat_sub(f00, stvk_pkg::Q_ONE));
      g11 = stvk_pkg::q_half(stvk_pkg::sat_sub(f11, stvk_pkg::Q_ONE));
      g01 = stvk_pkg::q_half(f01);
      hic = stvk_pkg::sat_sub(stvk_pkg::q_half(stvk_pkg::sat_add(f00, f11)),
                              stvk_pkg::Q_ONE);
      trg = stvk_pkg::sat_add(g00, g11);
      l3_a[0] = g00; l3_b[0] = g00;
      l3_a[1] = g11; l3_b[1] = g11;
      l3_a[2] = g01; l3_b[2] = g01;
      l3_a[3] = lam; l3_b[3] = trg;
      l3_a[4] = tmu; l3_b[4] = g00;
      l3_a[5] = tmu; l3_b[5] = g01;
      l3_a[6] = tmu; l3_b[6] = g11;
      l3_a[7] = hic; l3_b[7] = lam;
      for (int q = 0; q < stvk_pkg::NPAIR; q++) begin
         pa = l2_p[q];                                       // f0i*f0j
         pb = l2_p[6+q];                                     // f1i*f1j
         pc = l2_p[12+3*stvk_pkg::PAIR_I[q]+stvk_pkg::PAIR_J[q]]; // f0i*f1j
         pd = l2_p[12+3*stvk_pkg::PAIR_J[q]+stvk_pkg::PAIR_I[q]]; // f0j*f1i
         dgf0  = (stvk_pkg::PAIR_I[q] == stvk_pkg::PAIR_J[q]) ? f00 : stvk_pkg::Q_ZERO;
         dgf1  = (stvk_pkg::PAIR_I[q] == stvk_pkg::PAIR_J[q]) ? f11 : stvk_pkg::Q_ZERO;
         dgf01 = (stvk_pkg::PAIR_I[q] == stvk_pkg::PAIR_J[q]) ? f01 : stvk_pkg::Q_ZERO;
         in00 = stvk_pkg::sat_add(stvk_pkg::sat_add(dgf0, stvk_pkg::q_two(pa)), pb);
         in11 = stvk_pkg::sat_add(stvk_pkg::sat_add(dgf1, stvk_pkg::q_two(pb)), pa);
         l3_a[8+8*q]   = lam; l3_b[8+8*q]   = pa;
         l3_a[9+8*q]   = mu;  l3_b[9+8*q]   = in00;
         l3_a[10+8*q]  = lam; l3_b[10+8*q]  = pb;
         l3_a[11+8*q]  = mu;  l3_b[11+8*q]  = in11;
         l3_a[12+8*q]  = lam; l3_b[12+8*q]  = pc;
         l3_a[13+8*q]  = mu;  l3_b[13+8*q]  = stvk_pkg::sat_add(dgf01, pd);
         l3_a[14+8*q]  = lam; l3_b[14+8*q]  = pd;
         l3_a[15+8*q]  = mu;  l3_b[15+8*q]  = stvk_pkg::sat_add(dgf01, pc);
      end
   end

   for (genvar g = 0; g < N3; g++) begin : g_l3
      stvk_qmul u_mul (.clock(clock), .en(en), .a(l3_a[g]), .b(l3_b[g]), .p(l3_p[g]));
   end

   // ---------------- level 4: stress and weighted Hessian blocks ----------------
   stvk_pkg::q64_type c00, c01, c11, tdpsi, frob, dtp;
   stvk_pkg::q64_type h00, h11, hs;
   stvk_pkg::q64_type f0d [3], f1d [3], sd [3];
   logic below_floor;
   stvk_pkg::q64_type l4_a [N4], l4_b [N4], l4_p [N4];

   always_comb begin
      c00   = stvk_pkg::sat_add(l3_p[4], l3_p[3]);
      c01   = l3_p[5];
      c11   = stvk_pkg::sat_add(l3_p[6], l3_p[3]);
      tdpsi = stvk_pkg::sat_add(stvk_pkg::sat_neg(mu), l3_p[7]);
      frob  = stvk_pkg::sat_add(stvk_pkg::sat_add(l3_p[0], l3_p[1]),
                                stvk_pkg::q_two(l3_p[2]));
      below_floor = frob < stvk_pkg::q64_type'({32'h0, floor_ff});
      for (int i = 0; i < 3; i++) begin
         f0d[i] = fd_bus[64*i +: 64];
         f1d[i] = fd_bus[64*(3+i) +: 64];
         sd[i]  = sd_bus[64*i +: 64];
         l4_a[i]   = f0d[i]; l4_b[i]   = c00;
         l4_a[3+i] = f1d[i]; l4_b[3+i] = c01;
         l4_a[6+i] = f0d[i]; l4_b[6+i] = c01;
         l4_a[9+i] = f1d[i]; l4_b[9+i] = c11;
      end
      for (int q = 0; q < stvk_pkg::NPAIR; q++) begin
         dtp = (stvk_pkg::PAIR_I[q] == stvk_pkg::PAIR_J[q]) ? tdpsi : stvk_pkg::Q_ZERO;
         h00 = stvk_pkg::sat_add(stvk_pkg::sat_add(l3_p[8+8*q], dtp), l3_p[9+8*q]);
         h11 = stvk_pkg::sat_add(stvk_pkg::sat_add(l3_p[10+8*q], dtp), l3_p[11+8*q]);
         hs  = stvk_pkg::sat_add(stvk_pkg::sat_add(l3_p[12+8*q], l3_p[13+8*q]),
                                 stvk_pkg::sat_add(l3_p[14+8*q], l3_p[15+8*q]));
         l4_a[12+3*q] = sd[0]; l4_b[12+3*q] = h00;
         l4_a[13+3*q] = sd[1]; l4_b[13+3*q] = h11;
         l4_a[14+3*q] = sd[2]; l4_b[14+3*q] = hs;
      end
   end

   for (genvar g = 0; g < N4; g++) begin : g_l4
      stvk_qmul u_mul (.clock(clock), .en(en), .a(l4_a[g]), .b(l4_b[g]), .p(l4_p[g]));
   end

   // corner weights ride along to level 5
   logic [2*64-1:0] kd_bus;
   stvk_dly #(.WIDTH(2*64), .DEPTH(8)) u_k_dly (
      .clock(clock), .en(en), .d({k1, k0}), .q(kd_bus));

   // ---------------- level 5: force projection ----------------
   stvk_pkg::q64_type hq [stvk_pkg::NPAIR];
   stvk_pkg::q64_type l5_a [N5], l5_b [N5], l5_p [N5];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l5_a[i]   = stvk_pkg::sat_add(l4_p[i], l4_p[3+i]);
         l5_b[i]   = kd_bus[63:0];
         l5_a[3+i] = stvk_pkg::sat_add(l4_p[6+i], l4_p[9+i]);
         l5_b[3+i] = kd_bus[127:64];
      end
      for (int q = 0; q < stvk_pkg::NPAIR; q++) begin
         hq[q] = stvk_pkg::sat_add(stvk_pkg::sat_add(l4_p[12+3*q], l4_p[13+3*q]),
                                   l4_p[14+3*q]);
      end
   end

   for (genvar g = 0; g < N5; g++) begin : g_l5
      stvk_qmul u_mul (.clock(clock), .en(en), .a(l5_a[g]), .b(l5_b[g]), .p(l5_p[g]));
   end

   // Hessian and flags wait for the force
   logic [6*64-1:0] h_bus, hd_bus;
   logic            errd, below_floor_d;
   always_comb begin
      for (int q = 0; q < stvk_pkg::NPAIR; q++) h_bus[64*q +: 64] = hq[q];
   end
   stvk_dly #(.WIDTH(6*64), .DEPTH(2)) u_h_dly (.clock(clock), .en(en), .d(h_bus), .q(hd_bus));
   stvk_dly #(.WIDTH(1), .DEPTH(10)) u_e_dly (
      .clock(clock), .en(en),
      .d(stvk_pkg::corner_type'(req_word.corner_index) == stvk_pkg::CORNER_BAD),
      .q(errd));
   stvk_dly #(.WIDTH(1), .DEPTH(4)) u_z_dly (
      .clock(clock), .en(en), .d(below_floor), .q(below_floor_d));

   // ---------------- output register ----------------
   stvk_pkg::q64_type frc_in [3], frc_ff [3], hes_ff [stvk_pkg::NPAIR];
   logic              err_ff, zero;

   always_comb begin
      zero = errd || below_floor_d;
      for (int i = 0; i < 3; i++) begin
         frc_in[i] = zero ? stvk_pkg::Q_ZERO
                   : stvk_pkg::sat_neg(stvk_pkg::sat_add(l5_p[i], l5_p[3+i]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_ff <= errd;
         for (int i = 0; i < 3; i++) frc_ff[i] <= frc_in[i];
         for (int q = 0; q < stvk_pkg::NPAIR; q++)
            hes_ff[q] <= zero ? stvk_pkg::Q_ZERO : stvk_pkg::q64_type'(hd_bus[64*q +: 64]);
      end
   end

   assign rsp_word.valid       = rsp_vld_ff;
   assign rsp_word.force_x     = frc_ff[0];
   assign rsp_word.force_y     = frc_ff[1];
   assign rsp_word.force_z     = frc_ff[2];
   assign rsp_word.hess_xx     = hes_ff[0];
   assign rsp_word.hess_xy     = hes_ff[1];
   assign rsp_word.hess_xz     = hes_ff[2];
   assign rsp_word.hess_yy     = hes_ff[3];
   assign rsp_word.hess_yz     = hes_ff[4];
   assign rsp_word.hess_zz     = hes_ff[5];
   assign rsp_word.order_error = err_ff;

   // ---------------- assertions ----------------
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && err_ff |-> frc_ff[0] == stvk_pkg::Q_ZERO && hes_ff[5] == stvk_pkg::Q_ZERO)
      else $error("order_error word carries non-zero results");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      !en |=> vld_ff == $past(vld_ff))
      else $error("pipeline moved during a stall");

   a_csr_mu : assert property (@(posedge clock) disable iff (reset)
      csr_wr && csr_idx == stvk_pkg::CSR_SHEAR |=> mu_ff == $past(csr_pwdata))
      else $error("shear_modulus write lost");

endmodule
